// File: hw/rtl/sxh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxh_pkg: shared types and constants for the sponge hash
// IV, round constants and operation codes.
// ----------------------------------------------------------------------------
package sxh_pkg;

  localparam int unsigned MaxOutBytes = 512;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_ABSORB  = 2'd1,
    OP_SQUEEZE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef logic [63:0] word_t;
  typedef word_t [15:0] state_t;

  function automatic word_t iv_word(input logic [3:0] idx);
    case (idx)
      4'd0:  iv_word = 64'h7169486173682d31;
      4'd1:  iv_word = 64'h516875616e74756d;
      4'd2:  iv_word = 64'h496e746772747931;
      4'd3:  iv_word = 64'h4b44462d58304621;
      4'd4:  iv_word = 64'h9e3779b97f4a7c15;
      4'd5:  iv_word = 64'hbf58476d1ce4e5b9;
      4'd6:  iv_word = 64'h94d049bb133111eb;
      4'd7:  iv_word = 64'hd6e8feb86659fd93;
      4'd8:  iv_word = 64'ha4093822299f31d0;
      4'd9:  iv_word = 64'h082efa98ec4e6c89;
      4'd10: iv_word = 64'h452821e638d01377;
      4'd11: iv_word = 64'hbe5466cf34e90c6c;
      4'd12: iv_word = 64'hc0ac29b7c97c50dd;
      4'd13: iv_word = 64'h3f84d5b5b5470917;
      4'd14: iv_word = 64'h9216d5d98979fb1b;
      default: iv_word = 64'hd1310ba698dfb5ac;
    endcase
  endfunction

  function automatic word_t rc_word(input logic [4:0] idx);
    case (idx)
      5'd0:  rc_word = 64'h243f6a8885a308d3;
      5'd1:  rc_word = 64'h13198a2e03707344;
      5'd2:  rc_word = 64'ha4093822299f31d0;
      5'd3:  rc_word = 64'h082efa98ec4e6c89;
      5'd4:  rc_word = 64'h452821e638d01377;
      5'd5:  rc_word = 64'hbe5466cf34e90c6c;
      5'd6:  rc_word = 64'hc0ac29b7c97c50dd;
      5'd7:  rc_word = 64'h3f84d5b5b5470917;
      5'd8:  rc_word = 64'h9216d5d98979fb1b;
      5'd9:  rc_word = 64'hd1310ba698dfb5ac;
      5'd10: rc_word = 64'h2ffd72dbd01adfb7;
      5'd11: rc_word = 64'hb8e1afed6a267e96;
      5'd12: rc_word = 64'hba7c9045f12c7f99;
      5'd13: rc_word = 64'h24a19947b3916cf7;
      5'd14: rc_word = 64'h0801f2e2858efc16;
      5'd15: rc_word = 64'h636920d871574e69;
      5'd16: rc_word = 64'ha458fea3f4933d7e;
      5'd17: rc_word = 64'h0d95748f728eb658;
      5'd18: rc_word = 64'h718bcd5882154aee;
      5'd19: rc_word = 64'h7b54a41dc25a59b5;
      5'd20: rc_word = 64'h9c30d5392af26013;
      5'd21: rc_word = 64'hc5d1b023286085f0;
      5'd22: rc_word = 64'hca417918b8db38ef;
      default: rc_word = 64'h8e79dcb0603a180e;
    endcase
  endfunction

  // left rotate by a 6-bit amount
  function automatic word_t rotl(input word_t x, input logic [5:0] n);
    rotl = (x << n) | (x >> (7'd64 - {1'b0, n}));
  endfunction

endpackage

// File: hw/rtl/sxh_perm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxh_perm: 24-round sponge permutation
// One shared add-rotate-xor unit performs one state update per cycle:
// per round two constant injections, 32 quarter-mix half steps and 16
// cross-word xors.
// ----------------------------------------------------------------------------
module sxh_perm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sxh_pkg::state_t state_i,
  output sxh_pkg::state_t state_o,
  output logic            busy_o,
  output logic            done_o
);
  import sxh_pkg::*;

  state_t      s_q;
  logic        busy_q, done_q;
  logic [4:0]  round_q;
  logic [5:0]  step_q;   // 0,1 inject; 2..33 mix; 34..49 cross xor

  logic [3:0]  ia, ib, ic, id, dst, src;
  logic [5:0]  amt;
  logic [2:0]  qm;
  logic [1:0]  sub;
  logic [3:0]  ci;
  logic [4:0]  rci;
  logic [7:0]  rot_t;
  word_t       nv;

  always_comb begin
    qm  = 3'((step_q - 6'd2) >> 2);
    sub = 2'(step_q - 6'd2);
    ci  = 4'(step_q - 6'd34);
    ia = 4'(qm[1:0]);
    ib = qm[2] ? {2'b01, 2'(qm[1:0] + 2'd1)} : {2'b01, qm[1:0]};
    ic = qm[2] ? {2'b10, 2'(qm[1:0] + 2'd2)} : {2'b10, qm[1:0]};
    id = qm[2] ? {2'b11, 2'(qm[1:0] + 2'd3)} : {2'b11, qm[1:0]};
    dst = 4'd0; nv = '0; src = 4'd0; amt = 6'd0; rci = 5'd0; rot_t = 8'd0;
    if (step_q == 6'd0) begin
      dst = round_q[3:0];
      nv  = s_q[dst] ^ rc_word(round_q);
    end else if (step_q == 6'd1) begin
      dst = 4'(round_q + 5'd5);
      nv  = s_q[dst] + rotl(rc_word(5'd23 - round_q), 6'(round_q + 5'd1));
    end else if (step_q < 6'd34) begin
      // each half step: add then xor-rotate into one word; the sum is written back as well
      case (sub)
        2'd0: begin dst = id; nv = rotl(s_q[id] ^ (s_q[ia] + s_q[ib]), 6'd32); end
        2'd1: begin dst = ib; nv = rotl(s_q[ib] ^ (s_q[ic] + s_q[id]), 6'd24); end
        2'd2: begin dst = id; nv = rotl(s_q[id] ^ (s_q[ia] + s_q[ib]), 6'd16); end
        default: begin dst = ib; nv = rotl(s_q[ib] ^ (s_q[ic] + s_q[id]), 6'd63); end
      endcase
    end else begin
      dst = ci;
      src = 4'(ci + 4'd7);
      rci = (({1'b0, round_q} + {2'b00, ci}) >= 6'd24) ? 5'(round_q + 5'(ci) - 5'd24)
                                                      : 5'(round_q + 5'(ci));
      // (7i + r) % 63 + 1 with 7i + r <= 128
      rot_t = 8'(ci) * 8'd7 + 8'(round_q);
      if (rot_t >= 8'd126) rot_t = rot_t - 8'd126;
      else if (rot_t >= 8'd63) rot_t = rot_t - 8'd63;
      amt = 6'(rot_t + 8'd1);
      nv = s_q[dst] ^ rotl(s_q[src] + rc_word(rci), amt);
    end
  end

  // the add part of the quarter mix is written back with the word it feeds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; round_q <= '0; step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1; round_q <= '0; step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 6'd49) begin
          step_q <= '0;
          if (round_q == 5'd23) begin busy_q <= 1'b0; done_q <= 1'b1; end
          else round_q <= round_q + 5'd1;
        end else step_q <= step_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) s_q <= state_i;
    else if (busy_q) begin
      s_q[dst] <= nv;
      if (step_q >= 6'd2 && step_q < 6'd34) begin
        if (!sub[0]) s_q[ia] <= s_q[ia] + s_q[ib];
        else         s_q[ic] <= s_q[ic] + s_q[id];
      end
    end
  end

  assign state_o = s_q;
  assign busy_o  = busy_q;
  assign done_o  = done_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (round_q < 5'd24 && step_q < 6'd50)) else $error("counter range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q) else $error("start lost");
endmodule

// File: hw/rtl/sponge_xof_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sponge_xof_hash: extendable-output sponge hash
// Byte absorb, padding and word squeeze around an iterative permutation.
// ----------------------------------------------------------------------------
// An init or absorb word is taken while idle; the absorb which fills
// the 64-byte block starts a permutation, and a squeeze that pads does too.
// The permutation runs on one shared add-rotate-xor unit, one update step a
// cycle, and its result is registered back into the hash state;
// s_axis_tready stays low meanwhile.
// A squeeze emits ceil(len/8) words, one a cycle when the output is taken,
// with a permutation between 64-byte blocks. Lengths above 512 saturate.
module sponge_xof_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // operation[1:0], data_byte[9:2], out_len[19:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // out_word[63:0], valid_bytes[67:64]
  output logic        m_axis_tlast   // last
);
  import sxh_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PERM, ST_EMIT} st_e;

  st_e          st_q;
  state_t       s_q;
  logic [511:0] buf_q;          // pending block, byte i in bits 8i+7..8i
  logic [5:0]   pos_q;
  logic         padded_q;
  logic [9:0]   rem_q;
  logic [2:0]   widx_q;
  logic         emit_after_q;   // permutation leads into emission
  logic         perm_start;
  state_t       perm_in, perm_out;
  logic         perm_busy, perm_done;
  logic [63:0]  owd_q;
  logic [3:0]   ovb_q;
  logic         olast_q, ovalid_q;

  logic [1:0]   op;
  logic [9:0]   len_in, len_sat;
  state_t       mixed;

  assign op      = s_axis_tdata[1:0];
  assign len_in  = s_axis_tdata[19:10];
  assign len_sat = (len_in > 10'(MaxOutBytes)) ? 10'(MaxOutBytes) : len_in;
  assign s_axis_tready = (st_q == ST_IDLE);

  // block xored into the rate, with padding applied when asked
  function automatic state_t xor_block(input state_t s, input logic [511:0] b,
                                       input logic pad, input logic [5:0] p,
                                       input logic [7:0] lastb, input logic full);
    state_t r;
    logic [511:0] blk;
    r = s;
    blk = b;
    if (full) blk[511:504] = lastb;
    if (pad) begin
      blk[{p, 3'b000} +: 8] = blk[{p, 3'b000} +: 8] ^ 8'h1f;
      blk[511:504] = blk[511:504] ^ 8'h80;
    end
    for (int i = 0; i < 8; i++) r[i] = r[i] ^ blk[i*64 +: 64];
    return r;
  endfunction

  always_comb begin
    perm_start = 1'b0;
    perm_in    = s_q;
    mixed      = s_q;
    if (st_q == ST_IDLE && s_axis_tvalid) begin
      if (op == OP_ABSORB && pos_q == 6'd63) begin
        perm_start = 1'b1;
        perm_in = xor_block(s_q, buf_q, 1'b0, pos_q, s_axis_tdata[9:2], 1'b1);
      end else if (op == OP_SQUEEZE && !padded_q) begin
        perm_start = 1'b1;
        perm_in = xor_block(s_q, buf_q, 1'b1, pos_q, 8'd0, 1'b0);
      end
    end else if (st_q == ST_EMIT && widx_q == 3'd7 && rem_q > 10'd8 &&
                 (!ovalid_q || m_axis_tready)) begin
      mixed[15][63] = ~s_q[15][63];
      perm_start = 1'b1;
      perm_in = mixed;
    end
  end

  sxh_perm u_perm (
    .clk_i, .rst_ni, .start_i(perm_start), .state_i(perm_in),
    .state_o(perm_out), .busy_o(perm_busy), .done_o(perm_done)
  );

  function automatic state_t init_state();
    state_t r;
    for (int i = 0; i < 16; i++) r[i] = iv_word(4'(i));
    r[0] = r[0] ^ 64'h5149484153482d58;
    r[1] = r[1] ^ 64'd64;
    r[2] = r[2] ^ 64'h0001000000000000;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; s_q <= init_state(); pos_q <= '0; padded_q <= 1'b0;
      rem_q <= '0; widx_q <= '0; emit_after_q <= 1'b0; ovalid_q <= 1'b0;
      owd_q <= '0; ovb_q <= '0; olast_q <= 1'b0;
      buf_q <= '0;
    end else begin
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (s_axis_tvalid) begin
          case (op)
            OP_INIT: begin
              s_q <= init_state(); pos_q <= '0; padded_q <= 1'b0;
              buf_q <= '0;
            end
            OP_ABSORB: begin
              if (pos_q == 6'd63) begin
                buf_q <= '0;
                emit_after_q <= 1'b0; st_q <= ST_PERM;
              end else buf_q[{pos_q, 3'b000} +: 8] <= s_axis_tdata[9:2];
              pos_q <= pos_q + 6'd1;
            end
            OP_SQUEEZE: begin
              rem_q <= len_sat; widx_q <= '0;
              if (!padded_q) begin
                padded_q <= 1'b1; pos_q <= '0;
                buf_q <= '0;
                emit_after_q <= 1'b1; st_q <= ST_PERM;
              end else if (len_sat != 10'd0) st_q <= ST_EMIT;
            end
            default: ;
          endcase
        end
        ST_PERM: if (perm_done) begin
          s_q <= perm_out;
          if (emit_after_q && rem_q != 10'd0) st_q <= ST_EMIT;
          else st_q <= ST_IDLE;
        end
        ST_EMIT: if (!ovalid_q || m_axis_tready) begin
          // drop one word into the output register
          ovalid_q <= 1'b1;
          if (rem_q < 10'd8) begin
            owd_q <= s_q[widx_q] & ((64'd1 << {rem_q[2:0], 3'b000}) - 64'd1);
            ovb_q <= {1'b0, rem_q[2:0]};
          end else begin
            owd_q <= s_q[widx_q]; ovb_q <= 4'd8;
          end
          olast_q <= (rem_q <= 10'd8);
          if (rem_q <= 10'd8) begin
            rem_q <= '0; st_q <= ST_IDLE;
          end else begin
            rem_q <= rem_q - 10'd8;
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              emit_after_q <= 1'b1; st_q <= ST_PERM;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'd0, ovb_q, owd_q};
  assign m_axis_tlast  = olast_q;

  a_perm_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    perm_busy |-> st_q == ST_PERM) else $error("perm outside perm state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_IDLE |-> !s_axis_tready) else $error("ready while busy");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 10'(MaxOutBytes)) else $error("length over maximum");
endmodule
